// File: rtl/core/scr_pkg.sv
package scr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_STROKES = 8;
    localparam int DEF_SUBSAMPLES  = 8;
    localparam int DEF_MAX_EDGE    = 256;

    // Pixel edge in fixed-point units.
    localparam int PIX_UNITS = 128;
    localparam int PIX_SHIFT = 7;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ICON_SIZE  = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH = 2'd1;
    localparam logic [1:0] REG_MIN_REACH  = 2'd2;

    // Configuration reset values.
    localparam logic [8:0] ICON_SIZE_RST  = 9'd16;
    localparam logic [7:0] HALF_WIDTH_RST = 8'd24;
    localparam logic [9:0] MIN_REACH_RST  = 10'd72;

    // Datapath steps; at most one multiply per step.
    typedef logic [4:0] t_step;
    localparam t_step ST_NONE = 5'd0;
    localparam t_step ST_RCH  = 5'd1;
    localparam t_step ST_R2   = 5'd2;
    localparam t_step ST_LD   = 5'd3;
    localparam t_step ST_AX   = 5'd4;
    localparam t_step ST_AY   = 5'd5;
    localparam t_step ST_EX   = 5'd6;
    localparam t_step ST_EY   = 5'd7;
    localparam t_step ST_RAD  = 5'd8;
    localparam t_step ST_D2A  = 5'd9;
    localparam t_step ST_D2B  = 5'd10;
    localparam t_step ST_LNA  = 5'd11;
    localparam t_step ST_LNB  = 5'd12;
    localparam t_step ST_ALA  = 5'd13;
    localparam t_step ST_ALB  = 5'd14;
    localparam t_step ST_IN   = 5'd15;
    localparam t_step ST_OUT  = 5'd16;
    localparam t_step ST_PSA  = 5'd17;
    localparam t_step ST_PSB  = 5'd18;
    localparam t_step ST_BFA  = 5'd19;
    localparam t_step ST_BFB  = 5'd20;
    localparam t_step ST_WXA  = 5'd21;
    localparam t_step ST_WXB  = 5'd22;
    localparam t_step ST_QA   = 5'd23;
    localparam t_step ST_QB   = 5'd24;
    localparam t_step ST_QC   = 5'd25;
    localparam t_step ST_DEC  = 5'd26;

    // Controller to datapath commands.
    typedef struct packed {
        t_step step;
        logic  start;
        logic  append;
        logic  adv_i;
        logic  adv_j;
        logic  load_cov;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic hit;
        logic skip;
    } t_dp_stat;

    // One stored stroke.
    typedef struct packed {
        logic [8:0]        sx;
        logic [8:0]        sy;
        logic [8:0]        ex;
        logic [8:0]        ey;
        logic [8:0]        radius;
        logic signed [7:0] ox;
        logic signed [7:0] oy;
        logic signed [7:0] cx;
        logic signed [7:0] cy;
    } t_stroke;

    typedef logic signed [33:0] t_op;

endpackage

// File: rtl/core/scr_ctrl.sv
module scr_ctrl #(
    parameter int MAX_STROKES = 8,
    parameter int SUBSAMPLES  = 8,
    parameter int IW          = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  scr_pkg::t_dp_stat  i_stat,
    output scr_pkg::t_dp_cmd   o_ctl,
    output logic [IW-1:0]      o_addr
);
    import scr_pkg::*;

    localparam int TW  = $clog2(MAX_STROKES + 1);
    localparam int SBW = (SUBSAMPLES > 1) ? $clog2(SUBSAMPLES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RCH  = 3'd1;
    localparam logic [2:0] S_R2   = 3'd2;
    localparam logic [2:0] S_TEST = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]     r_state, n_state;
    t_step          r_step, n_step;
    logic [TW-1:0]  r_total, n_total;
    logic [IW-1:0]  r_k, n_k;
    logic [SBW-1:0] r_i, n_i, r_j, n_j;
    logic           r_ovalid, n_ovalid;
    logic           accept, last_k, last_i, last_j;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && o_in_ready;
    assign last_k      = (TW'(r_k) == r_total - TW'(1));
    assign last_i      = (r_i == SBW'(SUBSAMPLES - 1));
    assign last_j      = (r_j == SBW'(SUBSAMPLES - 1));

    // Sequencer: per subsample, each stroke in turn runs the step list.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_total = r_total;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        o_ctl   = '0;
        o_addr  = r_k;
        case (r_state)
            S_IDLE: begin
                o_addr = r_total[IW-1:0];
                if (accept) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_total = '0;
                        end
                        CMD_APPEND: begin
                            if (r_total < TW'(MAX_STROKES)) begin
                                o_ctl.append = 1'b1;
                                n_total      = r_total + TW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            o_ctl.start = 1'b1;
                            n_k         = '0;
                            n_i         = '0;
                            n_j         = '0;
                            n_state     = (i_stat.skip || r_total == '0) ? S_FIN : S_RCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_RCH: begin
                o_ctl.step = ST_RCH;
                n_state    = S_R2;
            end
            S_R2: begin
                o_ctl.step = ST_R2;
                n_step     = ST_LD;
                n_state    = S_TEST;
            end
            S_TEST: begin
                o_ctl.step = r_step;
                if (r_step != ST_DEC) begin
                    n_step = r_step + t_step'(1);
                end else begin
                    n_step = ST_LD;
                    if (i_stat.hit || last_k) begin
                        n_k = '0;
                        if (last_i) begin
                            n_i         = '0;
                            o_ctl.adv_j = 1'b1;
                            n_j         = r_j + SBW'(1);
                            if (last_j) begin
                                n_state = S_FIN;
                            end
                        end else begin
                            n_i         = r_i + SBW'(1);
                            o_ctl.adv_i = 1'b1;
                        end
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.load_cov = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result beat is held until the consumer takes it.
    assign n_ovalid = o_ctl.load_cov ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_NONE;
            r_total  <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_total  <= n_total;
            r_k      <= n_k;
            r_i      <= n_i;
            r_j      <= n_j;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// File: rtl/core/scr_datapath.sv
module scr_datapath #(
    parameter int MAX_STROKES = 8,
    parameter int SUBSAMPLES  = 8,
    parameter int MAX_EDGE    = 256,
    parameter int IW          = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scr_pkg::t_dp_cmd   i_ctl,
    input  logic [IW-1:0]      i_addr,
    output scr_pkg::t_dp_stat  o_stat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic [8:0]         i_start_x,
    input  logic [8:0]         i_start_y,
    input  logic [8:0]         i_end_x,
    input  logic [8:0]         i_end_y,
    input  logic [8:0]         i_arc_radius,
    input  logic signed [7:0]  i_open_dir_x,
    input  logic signed [7:0]  i_open_dir_y,
    input  logic signed [7:0]  i_close_dir_x,
    input  logic signed [7:0]  i_close_dir_y,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    output logic [7:0]         o_coverage
);
    import scr_pkg::*;

    localparam int SS    = SUBSAMPLES * SUBSAMPLES;
    localparam int CW    = $clog2(SS + 1);
    localparam int STEP  = PIX_UNITS / SUBSAMPLES;
    localparam int HALF  = STEP / 2;

    // Configuration registers.
    logic [8:0] r_size;
    logic [7:0] r_hw;
    logic [9:0] r_min_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= ICON_SIZE_RST;
            r_hw        <= HALF_WIDTH_RST;
            r_min_reach <= MIN_REACH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ICON_SIZE:  r_size      <= i_cfg_data[8:0];
                REG_HALF_WIDTH: r_hw        <= i_cfg_data[7:0];
                REG_MIN_REACH:  r_min_reach <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stroke table with a registered read port.
    t_stroke mem [MAX_STROKES];
    t_stroke r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            mem[i_addr] <= '{sx: i_start_x, sy: i_start_y, ex: i_end_x, ey: i_end_y,
                             radius: i_arc_radius, ox: i_open_dir_x, oy: i_open_dir_y,
                             cx: i_close_dir_x, cy: i_close_dir_y};
        end
        if (i_ctl.step == ST_LD) begin
            r_ent <= mem[i_addr];
        end
    end

    // Datapath registers.
    logic [14:0]        r_px0, r_px, r_py;
    logic [CW-1:0]      r_count;
    logic [13:0]        r_reach;
    logic [27:0]        r_r2;
    logic [14:0]        r_ax, r_ay, r_rad;
    logic signed [16:0] r_vx, r_vy, r_dx, r_dy;
    logic signed [63:0] r_acc;
    logic [31:0]        r_d2, r_len, r_out2;
    logic [29:0]        r_in2;
    logic signed [32:0] r_along;
    logic [32:0]        r_w2;
    logic               r_past, r_before;
    logic [63:0]        r_lhs, r_rhs;
    logic [7:0]         r_cov;

    // Shared multiplier operands.
    t_op                mul_a, mul_b;
    logic signed [67:0] prod;
    logic [17:0]        pix_sum;
    logic [14:0]        pix;
    logic signed [63:0] acc_add, acc_sub;
    logic [14:0]        inner;
    logic [15:0]        outer;
    logic signed [17:0] wx, wy;

    assign inner = (r_rad > 15'(r_reach)) ? r_rad - 15'(r_reach) : '0;
    assign outer = 16'(r_rad) + 16'(r_reach);
    assign wx    = 18'(r_vx) - 18'(r_dx);
    assign wy    = 18'(r_vy) - 18'(r_dy);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctl.step)
            ST_RCH: begin mul_a = 34'(r_hw);         mul_b = 34'(r_size); end
            ST_R2:  begin mul_a = 34'(r_reach);      mul_b = 34'(r_reach); end
            ST_AX:  begin mul_a = 34'(r_ent.sx);     mul_b = 34'(r_size); end
            ST_AY:  begin mul_a = 34'(r_ent.sy);     mul_b = 34'(r_size); end
            ST_EX:  begin mul_a = 34'(r_ent.ex);     mul_b = 34'(r_size); end
            ST_EY:  begin mul_a = 34'(r_ent.ey);     mul_b = 34'(r_size); end
            ST_RAD: begin mul_a = 34'(r_ent.radius); mul_b = 34'(r_size); end
            ST_D2A: begin mul_a = 34'(r_vx);         mul_b = 34'(r_vx); end
            ST_D2B: begin mul_a = 34'(r_vy);         mul_b = 34'(r_vy); end
            ST_LNA: begin mul_a = 34'(r_dx);         mul_b = 34'(r_dx); end
            ST_LNB: begin mul_a = 34'(r_dy);         mul_b = 34'(r_dy); end
            ST_ALA: begin mul_a = 34'(r_vx);         mul_b = 34'(r_dx); end
            ST_ALB: begin mul_a = 34'(r_vy);         mul_b = 34'(r_dy); end
            ST_IN:  begin mul_a = 34'(inner);        mul_b = 34'(inner); end
            ST_OUT: begin mul_a = 34'(outer);        mul_b = 34'(outer); end
            ST_PSA: begin mul_a = 34'(r_ent.ox);     mul_b = 34'(r_vy); end
            ST_PSB: begin mul_a = 34'(r_ent.oy);     mul_b = 34'(r_vx); end
            ST_BFA: begin mul_a = 34'(r_vx);         mul_b = 34'(r_ent.cy); end
            ST_BFB: begin mul_a = 34'(r_vy);         mul_b = 34'(r_ent.cx); end
            ST_WXA: begin mul_a = 34'(wx);           mul_b = 34'(wx); end
            ST_WXB: begin mul_a = 34'(wy);           mul_b = 34'(wy); end
            ST_QA:  begin mul_a = 34'(r_d2);         mul_b = 34'(r_len); end
            ST_QB:  begin mul_a = 34'(r_along);      mul_b = 34'(r_along); end
            ST_QC:  begin mul_a = 34'(r_r2);         mul_b = 34'(r_len); end
            default: ;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign pix_sum = {1'b0, prod[16:0]} + 18'd2;
    assign pix     = pix_sum[16:2];
    assign acc_add = r_acc + prod[63:0];
    assign acc_sub = r_acc - prod[63:0];

    // Step results.
    always_ff @(posedge i_clk) begin
        case (i_ctl.step)
            ST_RCH: r_reach <= (pix < 15'(r_min_reach)) ? 14'(r_min_reach) : pix[13:0];
            ST_R2:  r_r2    <= prod[27:0];
            ST_AX:  r_ax    <= pix;
            ST_AY: begin
                r_ay <= pix;
                r_vx <= $signed({2'b00, r_px}) - $signed({2'b00, r_ax});
            end
            ST_EX: begin
                r_dx <= $signed({2'b00, pix}) - $signed({2'b00, r_ax});
                r_vy <= $signed({2'b00, r_py}) - $signed({2'b00, r_ay});
            end
            ST_EY:  r_dy    <= $signed({2'b00, pix}) - $signed({2'b00, r_ay});
            ST_RAD: r_rad   <= pix;
            ST_D2A: r_acc   <= prod[63:0];
            ST_D2B: r_d2    <= acc_add[31:0];
            ST_LNA: r_acc   <= prod[63:0];
            ST_LNB: r_len   <= acc_add[31:0];
            ST_ALA: r_acc   <= prod[63:0];
            ST_ALB: r_along <= acc_add[32:0];
            ST_IN:  r_in2   <= prod[29:0];
            ST_OUT: r_out2  <= prod[31:0];
            ST_PSA: r_acc   <= prod[63:0];
            ST_PSB: r_past  <= !acc_sub[63];
            ST_BFA: r_acc   <= prod[63:0];
            ST_BFB: r_before <= !acc_sub[63];
            ST_WXA: r_acc   <= prod[63:0];
            ST_WXB: r_w2    <= acc_add[32:0];
            ST_QA:  r_lhs   <= prod[63:0];
            ST_QB:  r_acc   <= prod[63:0];
            ST_QC:  r_rhs   <= acc_add;
            default: ;
        endcase
    end

    // Hit decision for the current stroke and subsample.
    logic is_arc, ring_ok, arc_hit, seg_hit, near_start, past_end;

    assign is_arc     = (r_ent.radius != '0);
    assign ring_ok    = !(r_d2 < 32'(r_in2)) && !(r_d2 > r_out2);
    assign arc_hit    = ring_ok && !(r_past && r_before);
    assign near_start = (r_len == '0) || (r_along <= 33'sd0);
    assign past_end   = (r_along >= $signed({1'b0, r_len}));

    always_comb begin
        if (near_start) begin
            seg_hit = (r_d2 <= 32'(r_r2));
        end else if (past_end) begin
            seg_hit = (r_w2 <= 33'(r_r2));
        end else begin
            seg_hit = (r_lhs <= r_rhs);
        end
    end

    assign o_stat.hit  = (i_ctl.step == ST_DEC) && (is_arc ? arc_hit : seg_hit);
    assign o_stat.skip = (r_size == '0) || (r_size > 9'(MAX_EDGE)) ||
                         ({1'b0, i_pixel_x} >= r_size) || ({1'b0, i_pixel_y} >= r_size);

    // Subsample position and hit count.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_px0   <= {i_pixel_x, 7'd0} + 15'(HALF);
            r_px    <= {i_pixel_x, 7'd0} + 15'(HALF);
            r_py    <= {i_pixel_y, 7'd0} + 15'(HALF);
            r_count <= '0;
        end else begin
            if (i_ctl.adv_j) begin
                r_px <= r_px0;
                r_py <= r_py + 15'(STEP);
            end else if (i_ctl.adv_i) begin
                r_px <= r_px + 15'(STEP);
            end
            if (o_stat.hit) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Count to coverage scale as a constant table.
    logic [7:0] cov_lut [SS + 1];

    for (genvar g = 0; g <= SS; g++) begin : g_cov
        localparam int CV = g * 255 / SS;
        assign cov_lut[g] = 8'(CV);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cov) begin
            r_cov <= cov_lut[r_count];
        end
    end

    assign o_coverage = r_cov;

endmodule

// File: rtl/core/stroke_coverage_rasterizer_top.sv
// Clear and append beats are taken in the idle state; no result beat follows them.
// A query runs the reach setup steps, then T stroke tests: up to MAX_STROKES
// per subsample, fewer once a stroke hits, over SUBSAMPLES^2 subsamples.
// Each stroke test is a 24-step sequence through one shared 34x34 multiplier.
// Queries outside the icon or on an empty table skip the stroke tests.
// Synchronous active-low reset clears the table count, state and config.
module stroke_coverage_rasterizer_top #(
    parameter int MAX_STROKES = scr_pkg::DEF_MAX_STROKES,
    parameter int SUBSAMPLES  = scr_pkg::DEF_SUBSAMPLES,
    parameter int MAX_EDGE    = scr_pkg::DEF_MAX_EDGE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [8:0]        i_start_x,
    input  logic [8:0]        i_start_y,
    input  logic [8:0]        i_end_x,
    input  logic [8:0]        i_end_y,
    input  logic [8:0]        i_arc_radius,
    input  logic signed [7:0] i_open_dir_x,
    input  logic signed [7:0] i_open_dir_y,
    input  logic signed [7:0] i_close_dir_x,
    input  logic signed [7:0] i_close_dir_y,
    input  logic [7:0]        i_pixel_x,
    input  logic [7:0]        i_pixel_y,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_coverage
);
    import scr_pkg::*;

    localparam int IW = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;

    t_dp_cmd       ctl;
    t_dp_stat      stat;
    logic [IW-1:0] addr;

    // Sequencer.
    scr_ctrl #(
        .MAX_STROKES (MAX_STROKES),
        .SUBSAMPLES  (SUBSAMPLES),
        .IW          (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl),
        .o_addr      (addr)
    );

    // Stroke table, geometry arithmetic and coverage output.
    scr_datapath #(
        .MAX_STROKES (MAX_STROKES),
        .SUBSAMPLES  (SUBSAMPLES),
        .MAX_EDGE    (MAX_EDGE),
        .IW          (IW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_addr        (addr),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_arc_radius  (i_arc_radius),
        .i_open_dir_x  (i_open_dir_x),
        .i_open_dir_y  (i_open_dir_y),
        .i_close_dir_x (i_close_dir_x),
        .i_close_dir_y (i_close_dir_y),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_coverage    (o_coverage)
    );

endmodule

// File: rtl/core/scr_checker.sv
module scr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_cmd,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_coverage
);
    import scr_pkg::*;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coverage))
        else $error("result beat dropped or changed while stalled");

    // A query occupies the block, so input ready drops.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_QUERY |=> !o_in_ready)
        else $error("input taken again right after a query");

    // Table commands never create a result beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd != CMD_QUERY && !o_out_valid |=> !o_out_valid)
        else $error("result beat without a query");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind stroke_coverage_rasterizer_top scr_checker u_scr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_coverage  (o_coverage)
);

// File: bench/stroke_coverage_rasterizer_top_tb.sv
module stroke_coverage_rasterizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scr_pkg::*;

    localparam int         STROKE_SLOTS = DEF_MAX_STROKES;
    localparam int         GRID         = DEF_SUBSAMPLES;
    localparam int         EDGE_LIMIT   = DEF_MAX_EDGE;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         NO_VALUE     = -1;
    localparam int         SETTLE       = 16;

    // One input beat.
    typedef struct {
        logic [1:0]        cmd;
        logic [8:0]        sx;
        logic [8:0]        sy;
        logic [8:0]        ex;
        logic [8:0]        ey;
        logic [8:0]        rad;
        logic signed [7:0] ox;
        logic signed [7:0] oy;
        logic signed [7:0] cx;
        logic signed [7:0] cy;
        logic [7:0]        px;
        logic [7:0]        py;
    } t_beat;

    // A directed row; cov is NO_VALUE where the shadow model decides.
    typedef struct {
        t_beat b;
        int    cov;
    } t_row;

    // Shadow copy of one stored stroke.
    typedef struct {
        longint sx, sy, ex, ey, rad, ox, oy, cx, cy;
    } t_shape;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [9:0]        i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_cmd = '0;
    logic [8:0]        i_start_x = '0;
    logic [8:0]        i_start_y = '0;
    logic [8:0]        i_end_x = '0;
    logic [8:0]        i_end_y = '0;
    logic [8:0]        i_arc_radius = '0;
    logic signed [7:0] i_open_dir_x = '0;
    logic signed [7:0] i_open_dir_y = '0;
    logic signed [7:0] i_close_dir_x = '0;
    logic signed [7:0] i_close_dir_y = '0;
    logic [7:0]        i_pixel_x = '0;
    logic [7:0]        i_pixel_y = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_coverage;

    stroke_coverage_rasterizer_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow state of the block.
    t_shape     shapes [STROKE_SLOTS];
    int         shape_count = 0;
    longint     icon_edge = 16;
    longint     stroke_half = 24;
    longint     reach_floor = 72;
    logic [7:0] coverage_due [$];
    int         mismatches = 0;
    int         failures = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;
    t_row       rows [$];

    function automatic longint to_pix(longint g);
        return (g * icon_edge + 2) / 4;
    endfunction

    // Does one subsample point lie within reach of a stroke?
    function automatic bit reaches(t_shape s, longint reach, longint px, longint py);
        longint ax, ay, vx, vy, d2, r2, rad, inner, outer, dx, dy, len, along, wx, wy;
        bit past, ahead;
        ax = to_pix(s.sx);
        ay = to_pix(s.sy);
        vx = px - ax;
        vy = py - ay;
        d2 = vx * vx + vy * vy;
        r2 = reach * reach;
        if (s.rad != 0) begin
            rad = to_pix(s.rad);
            inner = rad - reach;
            outer = rad + reach;
            if (inner < 0) inner = 0;
            if (d2 < inner * inner || d2 > outer * outer) return 1'b0;
            // The gap wedge runs clockwise from the open to the close direction.
            past = (s.ox * vy - s.oy * vx) >= 0;
            ahead = (vx * s.cy - vy * s.cx) >= 0;
            return !(past && ahead);
        end
        dx = to_pix(s.ex) - ax;
        dy = to_pix(s.ey) - ay;
        len = dx * dx + dy * dy;
        along = vx * dx + vy * dy;
        if (len == 0 || along <= 0) return d2 <= r2;
        if (along >= len) begin
            wx = vx - dx;
            wy = vy - dy;
            return wx * wx + wy * wy <= r2;
        end
        return d2 * len - along * along <= r2 * len;
    endfunction

    function automatic logic [7:0] pixel_coverage(longint x, longint y);
        longint reach, stp, px, py;
        int covered;
        bit hit;
        covered = 0;
        if (icon_edge <= 0 || icon_edge > EDGE_LIMIT || x >= icon_edge || y >= icon_edge)
            return 8'd0;
        reach = to_pix(stroke_half);
        if (reach < reach_floor) reach = reach_floor;
        stp = PIX_UNITS / GRID;
        for (int j = 0; j < GRID; j++) begin
            for (int i = 0; i < GRID; i++) begin
                px = x * PIX_UNITS + stp / 2 + i * stp;
                py = y * PIX_UNITS + stp / 2 + j * stp;
                hit = 1'b0;
                for (int k = 0; k < shape_count && !hit; k++)
                    hit = reaches(shapes[k], reach, px, py);
                if (hit) covered++;
            end
        end
        return 8'((covered * 255) / (GRID * GRID));
    endfunction

    // Applies an accepted beat to the shadow state and queues its coverage.
    task automatic track_beat(t_beat b, int typed);
        case (b.cmd)
            CMD_CLEAR: shape_count = 0;
            CMD_APPEND: begin
                if (shape_count < STROKE_SLOTS) begin
                    shapes[shape_count] = '{b.sx, b.sy, b.ex, b.ey, b.rad,
                                            b.ox, b.oy, b.cx, b.cy};
                    shape_count++;
                end
            end
            CMD_QUERY: begin
                if (typed == NO_VALUE) coverage_due.push_back(pixel_coverage(b.px, b.py));
                else coverage_due.push_back(8'(typed));
            end
            default: ;
        endcase
    endtask

    // Offers one beat, with an optional random gap first, and waits for it.
    task automatic offer_beat(t_beat b, int typed);
        int gap;
        if (!calm && $urandom_range(99) < 24) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= b.cmd;
        i_start_x     <= b.sx;
        i_start_y     <= b.sy;
        i_end_x       <= b.ex;
        i_end_y       <= b.ey;
        i_arc_radius  <= b.rad;
        i_open_dir_x  <= b.ox;
        i_open_dir_y  <= b.oy;
        i_close_dir_x <= b.cx;
        i_close_dir_y <= b.cy;
        i_pixel_x     <= b.px;
        i_pixel_y     <= b.py;
        do @(posedge i_clk); while (!o_in_ready);
        track_beat(b, typed);
    endtask

    task automatic drain_results();
        while (coverage_due.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic write_reg(logic [1:0] idx, int value);
        i_in_valid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 10'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ICON_SIZE:  icon_edge = value & 'h1FF;
            REG_HALF_WIDTH: stroke_half = value & 'hFF;
            REG_MIN_REACH:  reach_floor = value & 'h3FF;
            default: ;
        endcase
    endtask

    function automatic t_beat any_beat(logic [1:0] cmd);
        t_beat b;
        b.cmd = cmd;
        b.sx = 9'($urandom);
        b.sy = 9'($urandom);
        b.ex = 9'($urandom);
        b.ey = 9'($urandom);
        b.rad = 9'($urandom);
        b.ox = 8'($urandom);
        b.oy = 8'($urandom);
        b.cx = 8'($urandom);
        b.cy = 8'($urandom);
        b.px = 8'($urandom);
        b.py = 8'($urandom);
        return b;
    endfunction

    function automatic t_beat stroke_beat();
        t_beat b;
        b = any_beat(CMD_APPEND);
        if ($urandom_range(1)) b.rad = '0;
        if ($urandom_range(7) == 0) begin
            b.ex = b.sx;
            b.ey = b.sy;
        end
        return b;
    endfunction

    // Queries land inside the icon most of the time.
    function automatic t_beat query_beat();
        t_beat b;
        longint lim;
        b = any_beat(CMD_QUERY);
        lim = (icon_edge > EDGE_LIMIT) ? EDGE_LIMIT : icon_edge;
        if (lim > 0 && $urandom_range(9) != 0) begin
            b.px = 8'($urandom_range(int'(lim) - 1));
            b.py = 8'($urandom_range(int'(lim) - 1));
        end
        return b;
    endfunction

    // Random part of one phase: clear, a few strokes, a few queries, some noise.
    task automatic run_groups(int beats, bit pause_midway);
        int sent, n;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < beats) begin
            if ($urandom_range(5) != 0) begin
                offer_beat(any_beat(CMD_CLEAR), NO_VALUE);
                sent++;
            end
            n = ($urandom_range(15) == 0) ? 9 : $urandom_range(1, 3);
            repeat (n) begin
                offer_beat(stroke_beat(), NO_VALUE);
                sent++;
            end
            if ($urandom_range(9) == 0) begin
                offer_beat(any_beat(CMD_UNUSED), NO_VALUE);
                sent++;
            end
            n = $urandom_range(1, 3);
            repeat (n) begin
                offer_beat(query_beat(), NO_VALUE);
                sent++;
            end
            if (pause_midway && !paused && sent > beats / 2) begin
                i_in_valid <= 1'b0;
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    function automatic t_row mk(logic [1:0] cmd, int sx, int sy, int ex, int ey, int rad,
                                int ox, int oy, int cx, int cy, int px, int py, int cov);
        t_row r;
        r.b = '{cmd, 9'(sx), 9'(sy), 9'(ex), 9'(ey), 9'(rad),
                8'(ox), 8'(oy), 8'(cx), 8'(cy), 8'(px), 8'(py)};
        r.cov = cov;
        return r;
    endfunction

    // Stimulus.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty table, ignored code, extremes, full table, outside icon.
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 5, 5, 0));
        rows.push_back(mk(CMD_UNUSED, 511, 511, 511, 511, 511, -1, -1, -1, -1, 255, 255,
                          NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 0, 0, 511, 511, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 15, 15, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 16, 0, 0));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 0));
        rows.push_back(mk(CMD_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_APPEND, 100, 200, 100, 200, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 256, 256, 0, 0, 511, -128, 127, 127, -128, 0, 0,
                          NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 256, 256, 0, 0, 64, 127, 0, 0, 127, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 6, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 9, 8, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 511, 0, 0, 511, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 0, 511, 511, 511, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 300, 40, 0, 0, 200, 0, -128, -128, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 20, 400, 480, 60, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_APPEND, 511, 511, 511, 511, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        // Table is full now; this append must be dropped.
        rows.push_back(mk(CMD_APPEND, 128, 128, 384, 128, 0, 0, 0, 0, 0, 0, 0, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 4, NO_VALUE));
        rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 255, 0));
        foreach (rows[i]) offer_beat(rows[i].b, rows[i].cov);

        // Default setting, no idling, with a long output hold and a drain pause.
        calm = 1'b1;
        hold_req = 1'b1;
        run_groups(250, 1'b1);
        calm = 1'b0;

        write_reg(REG_ICON_SIZE, 256);
        write_reg(REG_HALF_WIDTH, 255);
        write_reg(REG_MIN_REACH, 1023);
        run_groups(200, 1'b0);

        write_reg(REG_ICON_SIZE, 0);
        run_groups(200, 1'b0);

        write_reg(REG_ICON_SIZE, 1);
        write_reg(REG_HALF_WIDTH, 0);
        write_reg(REG_MIN_REACH, 0);
        run_groups(200, 1'b0);

        write_reg(REG_ICON_SIZE, 511);
        run_groups(200, 1'b0);

        write_reg(REG_ICON_SIZE, 32);
        write_reg(REG_HALF_WIDTH, 8);
        write_reg(REG_MIN_REACH, 40);
        run_groups(250, 1'b0);

        write_reg(REG_ICON_SIZE, 16);
        write_reg(REG_HALF_WIDTH, 40);
        write_reg(REG_MIN_REACH, 1);
        run_groups(200, 1'b0);

        i_in_valid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold, checked against the queue.
    initial begin
        int hold_left;
        logic [7:0] want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (coverage_due.size() == 0) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected coverage beat %0d", o_coverage);
                end else begin
                    want = coverage_due.pop_front();
                    if (o_coverage !== want) begin
                        failures++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("coverage mismatch: expected %0d, got %0d",
                                     want, o_coverage);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
            end
        end
    end

    // Watchdog.
    initial begin
        #1_000_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/core/scr_pkg.sv
rtl/core/scr_ctrl.sv
rtl/core/scr_datapath.sv
rtl/core/stroke_coverage_rasterizer_top.sv
rtl/core/scr_checker.sv
bench/stroke_coverage_rasterizer_top_tb.sv
